FILE: hdl/probe_cache_lru_replace_unit_macros.svh
// Assertion macros for the probe cache LRU replace unit
`ifndef PROBE_CACHE_LRU_REPLACE_UNIT_MACROS_SVH
`define PROBE_CACHE_LRU_REPLACE_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define PCLRU_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pclru: invariant violated");

// trigger implies consequence in the next cycle
`define PCLRU_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("pclru: sequence check failed");

`endif

FILE: hdl/pclru_pkg.sv
// Package: constants, types and sequencer states of the probe cache LRU replace unit
`timescale 1ns / 1ps
`default_nettype none
package pclru_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int STEP_W   = SLOT_W + 1;
  localparam int KEY_W    = 64;
  localparam int STAMP_W  = 32;
  localparam int HALF     = CAPACITY / 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DECIDE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              key_we;
    logic              stamp_we;
    logic [SLOT_W-1:0] wr_addr;
    logic              clr_we;
    logic [SLOT_W-1:0] clr_addr;
  } store_ctl_t;

  typedef struct packed {
    logic match;
    logic empty;
    logic take;
  } cmp_res_t;

endpackage
`default_nettype wire

FILE: hdl/probe_cache_lru_replace_unit.sv
// Top level: linear-probe key cache with LRU replacement, probe sequencer
//
//  channel | signals                                     | dir
//  in      | in_valid, in_stall, lookup_key              | beat in
//  out     | out_valid, out_stall, rejected, hit, slot,  | beat out
//          | replaced_old, extra_cleared, extra_slot     |
//
// Each probed slot takes a registered memory read (ST_READ), then a compare
// (ST_CHECK). A miss whose home slot is empty while the table is half full
// scans up to 64 slots ahead and clears the first occupied one it finds.
// A zero key skips the probe; input stalls until each result is registered.
// Reset empties the table at once through the occupied bits; no clearing pass.
// The output register holds a finished beat while the next key is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "probe_cache_lru_replace_unit_macros.svh"
module probe_cache_lru_replace_unit
  import pclru_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  lookup_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              rejected,
  output logic              hit,
  output logic [SLOT_W-1:0] slot,
  output logic              replaced_old,
  output logic              extra_cleared,
  output logic [SLOT_W-1:0] extra_slot
);

  state_t state, state_next;

  logic [KEY_W-1:0]   key_r;
  logic [SLOT_W-1:0]  idx;
  logic [STEP_W-1:0]  steps;
  logic               have_lru;
  logic [SLOT_W-1:0]  lru;
  logic [STAMP_W-1:0] lru_stamp;
  logic               found_empty;
  logic [SLOT_W-1:0]  target;
  logic               res_rej;
  logic               res_hit;
  logic               res_rep;
  logic               res_clr;
  logic [SLOT_W-1:0]  res_xslot;
  logic [STAMP_W-1:0] use_clock;
  logic [CNT_W-1:0]   count;

  store_ctl_t         ctl;
  logic [KEY_W-1:0]   rd_key;
  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_vld;
  logic               scan_vld;
  logic [SLOT_W-1:0]  idx_inc;
  logic [STAMP_W-1:0] wr_stamp;
  cmp_res_t           cmp;

  logic in_acc;
  logic out_free;
  logic last_step;
  logic full_half;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign idx_inc   = SLOT_W'(idx + 1'b1);
  assign last_step = (steps == STEP_W'(CAPACITY - 1));
  assign full_half = (count >= CNT_W'(HALF));
  assign wr_stamp  = res_hit ? use_clock : STAMP_W'(use_clock + 1'b1);

  pclru_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (idx),
    .ctl       (ctl),
    .wr_key    (key_r),
    .wr_stamp  (wr_stamp),
    .scan_addr (idx_inc),
    .rd_key    (rd_key),
    .rd_stamp  (rd_stamp),
    .rd_vld    (rd_vld),
    .scan_vld  (scan_vld)
  );

  pclru_cmp u_cmp (
    .key       (key_r),
    .rd_key    (rd_key),
    .rd_vld    (rd_vld),
    .rd_stamp  (rd_stamp),
    .lru_stamp (lru_stamp),
    .have_lru  (have_lru),
    .res       (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (lookup_key == '0) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        priority if (cmp.match) begin
          state_next = ST_WRITE;
        end else if (cmp.empty || last_step) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DECIDE: begin
        if ((full_half || !found_empty) && !have_lru) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_SCAN: begin
        if (scan_vld || last_step) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = (state != ST_IDLE);
    ctl.key_we   = (state == ST_WRITE);
    ctl.stamp_we = (state == ST_WRITE);
    ctl.wr_addr  = target;
    ctl.clr_we   = (state == ST_SCAN) && scan_vld;
    ctl.clr_addr = idx_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      use_clock <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            key_r       <= lookup_key;
            idx         <= lookup_key[SLOT_W-1:0];
            steps       <= '0;
            have_lru    <= 1'b0;
            found_empty <= 1'b0;
            target      <= '0;
            res_rej     <= (lookup_key == '0);
            res_hit     <= 1'b0;
            res_rep     <= 1'b0;
            res_clr     <= 1'b0;
            res_xslot   <= '0;
          end
        end
        ST_READ: begin
        end
        ST_CHECK: begin
          priority if (cmp.match) begin
            res_hit <= 1'b1;
            target  <= idx;
          end else if (cmp.empty) begin
            found_empty <= 1'b1;
          end else begin
            if (cmp.take) begin
              lru       <= idx;
              lru_stamp <= rd_stamp;
              have_lru  <= 1'b1;
            end
            idx   <= idx_inc;
            steps <= STEP_W'(steps + 1'b1);
          end
        end
        ST_DECIDE: begin
          steps <= '0;
          if ((full_half || !found_empty) && have_lru) begin
            target  <= lru;
            res_rep <= 1'b1;
          end else begin
            target <= idx;
            if (!full_half && found_empty) begin
              count <= CNT_W'(count + 1'b1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_vld) begin
            res_clr   <= 1'b1;
            res_xslot <= idx_inc;
          end else begin
            idx   <= idx_inc;
            steps <= STEP_W'(steps + 1'b1);
          end
        end
        ST_WRITE: begin
          use_clock <= res_hit ? STAMP_W'(use_clock + 1'b1)
                               : STAMP_W'(use_clock + 2'd2);
        end
        ST_FINISH: begin
          if (out_free) begin
            rejected      <= res_rej;
            hit           <= res_hit;
            slot          <= target;
            replaced_old  <= res_rep;
            extra_cleared <= res_clr;
            extra_slot    <= res_xslot;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PCLRU_HOLDS(a_count_le_half, count <= CNT_W'(HALF))
  `PCLRU_NEXT(a_busy_after_accept, in_acc, in_stall)
  `PCLRU_HOLDS(a_hit_clean, !(out_valid && hit) || (!replaced_old && !extra_cleared))
  `PCLRU_HOLDS(a_clear_excl, !(out_valid && extra_cleared) || (!replaced_old && !hit))

endmodule
`default_nettype wire

FILE: hdl/pclru_store.sv
// Key and stamp memories with per-slot occupied bits
`timescale 1ns / 1ps
`default_nettype none
module pclru_store
  import pclru_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [SLOT_W-1:0]  rd_addr,
  input  store_ctl_t         ctl,
  input  logic [KEY_W-1:0]   wr_key,
  input  logic [STAMP_W-1:0] wr_stamp,
  input  logic [SLOT_W-1:0]  scan_addr,
  output logic [KEY_W-1:0]   rd_key,
  output logic [STAMP_W-1:0] rd_stamp,
  output logic               rd_vld,
  output logic               scan_vld
);

  logic [KEY_W-1:0]   key_mem   [CAPACITY];
  logic [STAMP_W-1:0] stamp_mem [CAPACITY];
  logic [CAPACITY-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[ctl.wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.stamp_we) begin
      stamp_mem[ctl.wr_addr] <= wr_stamp;
    end
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.key_we) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.clr_we) begin
        vld[ctl.clr_addr] <= 1'b0;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign scan_vld = vld[scan_addr];

endmodule
`default_nettype wire

FILE: hdl/pclru_cmp.sv
// Shared probe compare unit: key match, empty slot, older stamp
`timescale 1ns / 1ps
`default_nettype none
module pclru_cmp
  import pclru_pkg::*;
(
  input  logic [KEY_W-1:0]   key,
  input  logic [KEY_W-1:0]   rd_key,
  input  logic               rd_vld,
  input  logic [STAMP_W-1:0] rd_stamp,
  input  logic [STAMP_W-1:0] lru_stamp,
  input  logic               have_lru,
  output cmp_res_t           res
);

  always_comb begin
    res.match = rd_vld && (rd_key == key);
    res.empty = !rd_vld;
    res.take  = !have_lru || (rd_stamp < lru_stamp);
  end

endmodule
`default_nettype wire
